/* rtl/core/ssw_pkg.sv */
package ssw_pkg;

  typedef enum logic [1:0] {
    ST_OTHER    = 2'd0,
    ST_RUN      = 2'd1,
    ST_STOPPING = 2'd2,
    ST_FAULT    = 2'd3
  } esc_state_t;

  typedef enum logic {
    FUNC_TICK  = 1'b0,
    FUNC_PULSE = 1'b1
  } func_t;

  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_OVERSPEED_IV  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_UNDERSPEED_IV = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GRACE_TICKS   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_NO_PULSE_LIM  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_LIM   = 3'd4;

  localparam logic [14:0] RUN_CAP     = 15'd20000;
  localparam logic [13:0] TIMEOUT_CAP = 14'd10000;
  localparam logic [7:0]  NOPULSE_CAP = 8'd200;
  localparam logic [7:0]  COUNT_CAP   = 8'd255;
  localparam logic [7:0]  BAD_LIMIT   = 8'd5;
  localparam logic [7:0]  GOOD_LIMIT  = 8'd10;

  localparam int unsigned FLAG_OVER    = 0;
  localparam int unsigned FLAG_UNDER   = 1;
  localparam int unsigned FLAG_TIMEOUT = 2;

  typedef struct packed {
    func_t       func;
    esc_state_t  esc_state;
    logic [15:0] pulse_interval;
    logic [15:0] speed_freq;
  } ssw_in_t;

  typedef struct packed {
    logic overspeed_fault;
    logic underspeed_fault;
    logic timeout_fault;
    logic stop_done;
  } ssw_out_t;

  typedef struct packed {
    logic [15:0] overspeed_interval;
    logic [15:0] underspeed_interval;
    logic [14:0] underspeed_grace_ticks;
    logic [7:0]  no_pulse_limit_ticks;
    logic [13:0] timeout_limit_ticks;
  } ssw_cfg_t;

endpackage

/* rtl/core/ssw_cfg_regs.sv */
module ssw_cfg_regs
  import ssw_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  wr_en,
  input  logic [CFG_IDX_W-1:0]  wr_index,
  input  logic [CFG_DATA_W-1:0] wr_data,
  output ssw_cfg_t              cfg
);

  ssw_cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.overspeed_interval     <= 16'd1000;
      cfg_r.underspeed_interval    <= 16'd5000;
      cfg_r.underspeed_grace_ticks <= 15'd500;
      cfg_r.no_pulse_limit_ticks   <= 8'd100;
      cfg_r.timeout_limit_ticks    <= 14'd1600;
    end else if (wr_en) begin
      case (wr_index)
        REG_OVERSPEED_IV:  cfg_r.overspeed_interval     <= wr_data;
        REG_UNDERSPEED_IV: cfg_r.underspeed_interval    <= wr_data;
        REG_GRACE_TICKS:   cfg_r.underspeed_grace_ticks <= wr_data[14:0];
        REG_NO_PULSE_LIM:  cfg_r.no_pulse_limit_ticks   <= wr_data[7:0];
        REG_TIMEOUT_LIM:   cfg_r.timeout_limit_ticks    <= wr_data[13:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

/* rtl/core/ssw_judge.sv */
module ssw_judge
  import ssw_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     step,
  input  ssw_in_t  item,
  input  ssw_cfg_t cfg,
  output ssw_out_t result
);

  logic [14:0] run_ticks_r, run_ticks_nxt;
  logic [13:0] timeout_ticks_r, timeout_ticks_nxt;
  logic [7:0]  no_pulse_ticks_r, no_pulse_ticks_nxt;
  logic [7:0]  good_count_r, good_count_nxt;
  logic [7:0]  bad_count_r, bad_count_nxt;
  logic        pulse_seen_r, pulse_seen_nxt;
  esc_state_t  prev_state_r, prev_state_nxt;
  logic [2:0]  fault_flags_r, fault_flags_nxt;
  logic        stopped_r, stopped_nxt;

  always_comb begin
    logic run_st;
    logic stop_st;
    run_st  = (item.esc_state == ST_RUN);
    stop_st = (item.esc_state == ST_STOPPING);

    run_ticks_nxt      = run_ticks_r;
    timeout_ticks_nxt  = timeout_ticks_r;
    no_pulse_ticks_nxt = no_pulse_ticks_r;
    good_count_nxt     = good_count_r;
    bad_count_nxt      = bad_count_r;
    pulse_seen_nxt     = pulse_seen_r;
    prev_state_nxt     = prev_state_r;
    fault_flags_nxt    = fault_flags_r;
    stopped_nxt        = stopped_r;

    if (item.func == FUNC_PULSE) begin
      // pulses outside run or stopping are dropped
      if (run_st || stop_st) begin
        no_pulse_ticks_nxt = '0;
        pulse_seen_nxt     = 1'b1;
        if (item.pulse_interval < cfg.overspeed_interval) begin
          if (bad_count_nxt < COUNT_CAP) bad_count_nxt = bad_count_nxt + 8'd1;
          good_count_nxt = '0;
          if (bad_count_nxt >= BAD_LIMIT) begin
            fault_flags_nxt[FLAG_OVER] = 1'b1;
            run_ticks_nxt = '0;
          end
        end else begin
          if (good_count_nxt < COUNT_CAP) good_count_nxt = good_count_nxt + 8'd1;
          if (good_count_nxt >= GOOD_LIMIT) bad_count_nxt = '0;
        end
        if (run_st && (bad_count_nxt < BAD_LIMIT) &&
            (run_ticks_nxt > cfg.underspeed_grace_ticks) &&
            (item.pulse_interval > cfg.underspeed_interval)) begin
          fault_flags_nxt[FLAG_UNDER] = 1'b1;
          run_ticks_nxt = '0;
        end
      end
    end else begin
      if (run_st && (prev_state_r != ST_RUN)) begin
        run_ticks_nxt  = '0;
        bad_count_nxt  = '0;
        good_count_nxt = '0;
        pulse_seen_nxt = 1'b0;
      end else if (stop_st && (prev_state_r != ST_STOPPING)) begin
        stopped_nxt       = 1'b0;
        timeout_ticks_nxt = '0;
      end

      if (!run_st) begin
        if (timeout_ticks_nxt < TIMEOUT_CAP) timeout_ticks_nxt = timeout_ticks_nxt + 14'd1;
        if ((timeout_ticks_nxt > cfg.timeout_limit_ticks) && (item.speed_freq > 16'd1))
          fault_flags_nxt[FLAG_TIMEOUT] = 1'b1;
      end

      if (run_st || stop_st) begin
        if (run_ticks_nxt < RUN_CAP) run_ticks_nxt = run_ticks_nxt + 15'd1;
        if (pulse_seen_nxt) begin
          no_pulse_ticks_nxt = '0;
          pulse_seen_nxt     = 1'b0;
        end else if (run_st) begin
          if (no_pulse_ticks_nxt < NOPULSE_CAP)
            no_pulse_ticks_nxt = no_pulse_ticks_nxt + 8'd1;
          if ((run_ticks_nxt > cfg.underspeed_grace_ticks) &&
              (no_pulse_ticks_nxt > cfg.no_pulse_limit_ticks)) begin
            fault_flags_nxt[FLAG_UNDER] = 1'b1;
            run_ticks_nxt = '0;
          end
        end
        if (stop_st && (item.speed_freq == 16'd0)) stopped_nxt = 1'b1;
      end

      prev_state_nxt = item.esc_state;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_ticks_r      <= '0;
      timeout_ticks_r  <= '0;
      no_pulse_ticks_r <= '0;
      good_count_r     <= '0;
      bad_count_r      <= '0;
      pulse_seen_r     <= 1'b0;
      prev_state_r     <= ST_OTHER;
      fault_flags_r    <= '0;
      stopped_r        <= 1'b0;
    end else if (step) begin
      run_ticks_r      <= run_ticks_nxt;
      timeout_ticks_r  <= timeout_ticks_nxt;
      no_pulse_ticks_r <= no_pulse_ticks_nxt;
      good_count_r     <= good_count_nxt;
      bad_count_r      <= bad_count_nxt;
      pulse_seen_r     <= pulse_seen_nxt;
      prev_state_r     <= prev_state_nxt;
      fault_flags_r    <= fault_flags_nxt;
      stopped_r        <= stopped_nxt;
    end
  end

  assign result.overspeed_fault  = fault_flags_nxt[FLAG_OVER];
  assign result.underspeed_fault = fault_flags_nxt[FLAG_UNDER];
  assign result.timeout_fault    = fault_flags_nxt[FLAG_TIMEOUT];
  assign result.stop_done        = stopped_nxt;

endmodule

/* rtl/core/shaft_speed_window_monitor_unit.sv */
// An accepted request passes the input register, then the result register.
// Throughput: one request per cycle; the input register feeds the judge
// and result register in one pass; requests flow back to back unless stalled.
// Reset (synchronous, rst_n low): clears counters, fault flags and stop done,
// empties both registers and restores the threshold registers to defaults.
module shaft_speed_window_monitor_unit
  import ssw_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  ssw_in_t               in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output ssw_out_t              out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic     stage_valid_r;
  ssw_in_t  stage_data_r;
  logic     out_valid_r;
  ssw_out_t out_data_r;
  logic     advance;
  ssw_cfg_t cfg;
  ssw_out_t result;

  assign cfg_ready = 1'b1;

  ssw_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // move the held request into the result register when that slot frees up
  assign advance  = stage_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = stage_valid_r && !advance;

  ssw_judge u_judge (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (advance),
    .item   (stage_data_r),
    .cfg    (cfg),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_valid_r <= 1'b0;
    end else if (!in_stall) begin
      stage_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      stage_data_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* sim/tb_shaft_speed_window_monitor_unit.sv */
`timescale 1ns / 100ps

module tb_shaft_speed_window_monitor_unit;
  import ssw_pkg::*;

  localparam int QUIET_LIMIT = 1000;
  localparam int PHASE_QUOTA = 290;
  localparam int HOLD_CYCLES = 50;

  typedef struct packed {
    ssw_in_t  req;
    logic     known;
    ssw_out_t flags;  // over, under, timeout, stop done
  } dir_row_t;

  localparam int DIR_ROWS_N = 20;
  localparam dir_row_t DIR_ROWS [0:DIR_ROWS_N-1] = '{
    '{'{FUNC_TICK,  ST_OTHER,    16'h0000, 16'h0000}, 1'b1, 4'b0000},
    '{'{FUNC_PULSE, ST_OTHER,    16'hFFFF, 16'hFFFF}, 1'b1, 4'b0000},
    '{'{FUNC_PULSE, ST_FAULT,    16'h0000, 16'h0000}, 1'b1, 4'b0000},
    '{'{FUNC_TICK,  ST_FAULT,    16'h0000, 16'hFFFF}, 1'b1, 4'b0000},
    '{'{FUNC_TICK,  ST_STOPPING, 16'hFFFF, 16'h0000}, 1'b1, 4'b0001},
    '{'{FUNC_TICK,  ST_STOPPING, 16'h0000, 16'hFFFF}, 1'b1, 4'b0001},
    '{'{FUNC_PULSE, ST_STOPPING, 16'h0000, 16'h0000}, 1'b0, 4'b0000},
    '{'{FUNC_TICK,  ST_STOPPING, 16'h0000, 16'h0001}, 1'b0, 4'b0000},
    '{'{FUNC_TICK,  ST_RUN,      16'h0000, 16'hFFFF}, 1'b1, 4'b0001},
    '{'{FUNC_PULSE, ST_RUN,      16'hFFFF, 16'h0000}, 1'b0, 4'b0000},
    '{'{FUNC_TICK,  ST_RUN,      16'h0000, 16'h0064}, 1'b0, 4'b0000},
    '{'{FUNC_PULSE, ST_RUN,      16'h0000, 16'h0000}, 1'b0, 4'b0000},
    '{'{FUNC_PULSE, ST_RUN,      16'h0000, 16'h0000}, 1'b0, 4'b0000},
    '{'{FUNC_PULSE, ST_RUN,      16'h0000, 16'h0000}, 1'b0, 4'b0000},
    '{'{FUNC_PULSE, ST_RUN,      16'h0000, 16'h0000}, 1'b0, 4'b0000},
    '{'{FUNC_PULSE, ST_RUN,      16'h0000, 16'h0000}, 1'b1, 4'b1001},
    '{'{FUNC_PULSE, ST_RUN,      16'd999,  16'h0000}, 1'b0, 4'b0000},
    '{'{FUNC_PULSE, ST_RUN,      16'd1000, 16'h0000}, 1'b0, 4'b0000},
    '{'{FUNC_TICK,  ST_OTHER,    16'h0000, 16'h0000}, 1'b0, 4'b0000},
    '{'{FUNC_TICK,  ST_FAULT,    16'h0000, 16'h0002}, 1'b0, 4'b0000}
  };

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  ssw_in_t               in_data;
  logic                  out_valid;
  logic                  out_stall;
  ssw_out_t              out_data;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // expected flag sets, oldest first
  ssw_out_t flags_due[$];
  int       mismatches;

  logic lazy_in;
  logic lazy_out;
  logic hold_off;

  // shadow of thresholds and supervisor state
  ssw_cfg_t   thr;
  logic [14:0] run_cnt;
  logic [13:0] tmo_cnt;
  logic [7:0]  nopulse_cnt;
  logic [7:0]  good_cnt;
  logic [7:0]  bad_cnt;
  logic        pulse_seen;
  esc_state_t  last_st;
  logic [2:0]  fault_bits;
  logic        stopped;

  shaft_speed_window_monitor_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  task automatic judge_interval(input esc_state_t st, input logic [15:0] iv);
    nopulse_cnt = '0;
    pulse_seen = 1'b1;
    if (iv < thr.overspeed_interval) begin
      if (bad_cnt < COUNT_CAP) bad_cnt = bad_cnt + 8'd1;
      good_cnt = '0;
      if (bad_cnt >= BAD_LIMIT) begin
        fault_bits[FLAG_OVER] = 1'b1;
        run_cnt = '0;
      end
    end else begin
      if (good_cnt < COUNT_CAP) good_cnt = good_cnt + 8'd1;
      if (good_cnt >= GOOD_LIMIT) bad_cnt = '0;
    end
    if (st == ST_RUN && bad_cnt < BAD_LIMIT && run_cnt > thr.underspeed_grace_ticks &&
        iv > thr.underspeed_interval) begin
      fault_bits[FLAG_UNDER] = 1'b1;
      run_cnt = '0;
    end
  endtask

  task automatic count_tick(input esc_state_t st, input logic [15:0] freq);
    if (st == ST_RUN && last_st != ST_RUN) begin
      run_cnt = '0;
      bad_cnt = '0;
      good_cnt = '0;
      pulse_seen = 1'b0;
    end else if (st == ST_STOPPING && last_st != ST_STOPPING) begin
      stopped = 1'b0;
      tmo_cnt = '0;
    end
    if (st != ST_RUN) begin
      if (tmo_cnt < TIMEOUT_CAP) tmo_cnt = tmo_cnt + 14'd1;
      if (tmo_cnt > thr.timeout_limit_ticks && freq > 16'd1) fault_bits[FLAG_TIMEOUT] = 1'b1;
    end
    if (st == ST_RUN || st == ST_STOPPING) begin
      if (run_cnt < RUN_CAP) run_cnt = run_cnt + 15'd1;
      if (pulse_seen) begin
        nopulse_cnt = '0;
        pulse_seen = 1'b0;
      end else if (st == ST_RUN) begin
        if (nopulse_cnt < NOPULSE_CAP) nopulse_cnt = nopulse_cnt + 8'd1;
        if (run_cnt > thr.underspeed_grace_ticks && nopulse_cnt > thr.no_pulse_limit_ticks) begin
          fault_bits[FLAG_UNDER] = 1'b1;
          run_cnt = '0;
        end
      end
      if (st == ST_STOPPING && freq == 16'd0) stopped = 1'b1;
    end
    last_st = st;
  endtask

  task automatic advance_supervisor(input ssw_in_t req, output ssw_out_t flags);
    if (req.func == FUNC_PULSE) begin
      // drop pulses outside run and stopping
      if (req.esc_state == ST_RUN || req.esc_state == ST_STOPPING)
        judge_interval(req.esc_state, req.pulse_interval);
    end else begin
      count_tick(req.esc_state, req.speed_freq);
    end
    flags.overspeed_fault  = fault_bits[FLAG_OVER];
    flags.underspeed_fault = fault_bits[FLAG_UNDER];
    flags.timeout_fault    = fault_bits[FLAG_TIMEOUT];
    flags.stop_done        = stopped;
  endtask

  // entered and left at a falling edge; leaves in_valid high
  task automatic offer_request(input ssw_in_t req, input logic known, input ssw_out_t known_flags);
    int       gap;
    ssw_out_t pred;
    gap = lazy_in ? $urandom_range(0, 5) : 0;
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_data = req;
    do @(posedge clk); while (in_stall);
    advance_supervisor(req, pred);
    flags_due.push_back(known ? known_flags : pred);
    @(negedge clk);
  endtask

  task automatic write_threshold(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_index = idx;
    cfg_data = val;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_OVERSPEED_IV:  thr.overspeed_interval = val;
      REG_UNDERSPEED_IV: thr.underspeed_interval = val;
      REG_GRACE_TICKS:   thr.underspeed_grace_ticks = val[14:0];
      REG_NO_PULSE_LIM:  thr.no_pulse_limit_ticks = val[7:0];
      REG_TIMEOUT_LIM:   thr.timeout_limit_ticks = val[13:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic drain_results;
    in_valid = 1'b0;
    while (flags_due.size() != 0) @(posedge clk);
    repeat (4) @(negedge clk);
  endtask

  // flavor: 0 high extremes, 1 moderate, 2 full range, 3 tight, 4 low extremes
  function automatic ssw_cfg_t draw_thresholds(input int flavor);
    ssw_cfg_t c;
    case (flavor)
      0: c = '{16'd1, 16'hFFFF, 15'd20000, 8'd199, 14'd10000};
      1: begin
        c.overspeed_interval     = 16'($urandom_range(300, 1500));
        c.underspeed_interval    = 16'($urandom_range(3000, 8000));
        c.underspeed_grace_ticks = 15'($urandom_range(50, 300));
        c.no_pulse_limit_ticks   = 8'($urandom_range(10, 60));
        c.timeout_limit_ticks    = 14'($urandom_range(200, 500));
      end
      2: begin
        c.overspeed_interval     = 16'($urandom_range(1, 65535));
        c.underspeed_interval    = 16'($urandom_range(1, 65535));
        c.underspeed_grace_ticks = 15'($urandom_range(0, 20000));
        c.no_pulse_limit_ticks   = 8'($urandom_range(0, 199));
        c.timeout_limit_ticks    = 14'($urandom_range(0, 10000));
      end
      3: begin
        c.overspeed_interval     = 16'($urandom_range(100, 4000));
        c.underspeed_interval    = 16'($urandom_range(4000, 20000));
        c.underspeed_grace_ticks = 15'($urandom_range(0, 40));
        c.no_pulse_limit_ticks   = 8'($urandom_range(0, 10));
        c.timeout_limit_ticks    = 14'($urandom_range(0, 100));
      end
      default: c = '{16'hFFFF, 16'd1, 15'd0, 8'd0, 14'd0};
    endcase
    return c;
  endfunction

  task automatic program_thresholds(input ssw_cfg_t c);
    logic [CFG_IDX_W-1:0] bad_idx;
    bad_idx = CFG_IDX_W'($urandom_range(5, 7));
    write_threshold(REG_OVERSPEED_IV, c.overspeed_interval);
    write_threshold(REG_UNDERSPEED_IV, c.underspeed_interval);
    write_threshold(REG_GRACE_TICKS, CFG_DATA_W'(c.underspeed_grace_ticks));
    write_threshold(REG_NO_PULSE_LIM, CFG_DATA_W'(c.no_pulse_limit_ticks));
    write_threshold(REG_TIMEOUT_LIM, CFG_DATA_W'(c.timeout_limit_ticks));
    // unused index must leave every threshold alone
    write_threshold(bad_idx, CFG_DATA_W'($urandom_range(0, 65535)));
    cfg_valid = 1'b0;
  endtask

  // kind: 0 short, 1 in window, 2 long, 3 extreme or anything
  function automatic logic [15:0] pick_interval(input int kind);
    int lo;
    int hi;
    int r;
    lo = thr.overspeed_interval;
    hi = thr.underspeed_interval;
    case (kind)
      0: return (lo == 0) ? 16'd0 : 16'($urandom_range(0, lo - 1));
      1: return (hi > lo) ? 16'($urandom_range(lo, hi)) : 16'($urandom_range(lo, 65535));
      2: return (hi >= 65535) ? 16'hFFFF : 16'($urandom_range(hi + 1, 65535));
      default: begin
        r = $urandom_range(0, 2);
        return (r == 0) ? 16'h0000 : (r == 1) ? 16'hFFFF : 16'($urandom_range(0, 65535));
      end
    endcase
  endfunction

  function automatic logic [15:0] pick_freq;
    int r;
    r = $urandom_range(0, 99);
    if (r < 20) return 16'd0;
    if (r < 35) return 16'd1;
    if (r < 50) return 16'd2;
    if (r < 60) return 16'hFFFF;
    return 16'($urandom_range(0, 65535));
  endfunction

  // runs of one machine state with pulses mixed in, plus some noise
  task automatic run_episodes(input int quota);
    int         counted;
    int         len;
    int         pulse_pct;
    int         r;
    int         kind;
    logic       short_bias;
    esc_state_t ep_st;
    ssw_in_t    req;
    counted = 0;
    while (counted < quota) begin
      r = $urandom_range(0, 99);
      ep_st = (r < 45) ? ST_RUN : (r < 70) ? ST_STOPPING : (r < 88) ? ST_OTHER : ST_FAULT;
      len = $urandom_range(3, 40);
      r = $urandom_range(0, 9);
      pulse_pct = (r < 2) ? 0 : (r < 6) ? 35 : 70;
      if (ep_st == ST_OTHER || ep_st == ST_FAULT) pulse_pct = pulse_pct / 5;
      short_bias = ($urandom_range(0, 4) == 0);
      lazy_in = ($urandom_range(0, 3) != 0);
      lazy_out = ($urandom_range(0, 3) != 0);
      for (int k = 0; k < len; k++) begin
        if ($urandom_range(0, 99) < 8) begin
          req.func = func_t'(1'($urandom_range(0, 1)));
          req.esc_state = esc_state_t'(2'($urandom_range(0, 3)));
          req.pulse_interval = 16'($urandom_range(0, 65535));
          req.speed_freq = 16'($urandom_range(0, 65535));
        end else begin
          req.esc_state = ep_st;
          if ($urandom_range(0, 99) < pulse_pct) begin
            req.func = FUNC_PULSE;
            r = $urandom_range(0, 99);
            if (short_bias) kind = (r < 70) ? 0 : 1;
            else kind = (r < 12) ? 0 : (r < 80) ? 1 : (r < 95) ? 2 : 3;
            req.pulse_interval = pick_interval(kind);
            req.speed_freq = pick_freq();
          end else begin
            req.func = FUNC_TICK;
            req.pulse_interval = 16'($urandom_range(0, 65535));
            // let the shaft come to rest late in a stopping run
            if (ep_st == ST_STOPPING && k > len / 2 && $urandom_range(0, 9) < 6)
              req.speed_freq = 16'd0;
            else
              req.speed_freq = pick_freq();
          end
        end
        offer_request(req, 1'b0, '0);
        if (!(req.func == FUNC_PULSE && req.esc_state != ST_RUN &&
              req.esc_state != ST_STOPPING))
          counted++;
      end
    end
  endtask

  // receiver: per-result stall, with one long hold-off
  initial begin : receiver
    int wait_cycles;
    out_stall = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_off) begin
        wait_cycles = HOLD_CYCLES;
        hold_off = 1'b0;
      end else begin
        wait_cycles = lazy_out ? $urandom_range(0, 5) : 0;
      end
      if (wait_cycles > 0) begin
        out_stall = 1'b1;
        repeat (wait_cycles) @(negedge clk);
        out_stall = 1'b0;
      end
      do @(posedge clk); while (!out_valid);
    end
  end

  always @(posedge clk) begin : result_check
    ssw_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (flags_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result %b with nothing pending", $realtime, out_data);
      end else begin
        want = flags_due.pop_front();
        if (out_data.overspeed_fault !== want.overspeed_fault ||
            out_data.underspeed_fault !== want.underspeed_fault ||
            out_data.timeout_fault !== want.timeout_fault ||
            out_data.stop_done !== want.stop_done) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: flags over/under/timeout/stop expected %b%b%b%b got %b%b%b%b",
                     $realtime, want.overspeed_fault, want.underspeed_fault,
                     want.timeout_fault, want.stop_done, out_data.overspeed_fault,
                     out_data.underspeed_fault, out_data.timeout_fault, out_data.stop_done);
        end
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int phase_flavor [0:5];
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    mismatches = 0;
    lazy_in = 1'b1;
    lazy_out = 1'b1;
    hold_off = 1'b0;
    thr = '{16'd1000, 16'd5000, 15'd500, 8'd100, 14'd1600};
    run_cnt = '0;
    tmo_cnt = '0;
    nopulse_cnt = '0;
    good_cnt = '0;
    bad_cnt = '0;
    pulse_seen = 1'b0;
    last_st = ST_OTHER;
    fault_bits = '0;
    stopped = 1'b0;
    phase_flavor = '{0, 1, 2, 3, 1, 4};

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    for (int i = 0; i < DIR_ROWS_N; i++)
      offer_request(DIR_ROWS[i].req, DIR_ROWS[i].known, DIR_ROWS[i].flags);

    for (int p = 0; p < 6; p++) begin
      drain_results();
      program_thresholds(draw_thresholds(phase_flavor[p]));
      if (p == 2) hold_off = 1'b1;
      run_episodes(PHASE_QUOTA);
    end

    in_valid = 1'b0;
    while (flags_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0 && flags_due.size() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
